/* hw/rtl/gpic_pkg.sv */
// ----------------------------------------------------------------------------
// gpic_pkg
// Shared constants, item kinds and a bit-search helper for the grouped priority
// interrupt controller.
// ----------------------------------------------------------------------------
package gpic_pkg;

  localparam int NUM_WORDS_DEF  = 3;
  localparam int NUM_GROUPS_DEF = 15;
  localparam int LINE_BITS      = 32;
  localparam int NUM_BITS       = 7;

  typedef enum logic [2:0] {
    KIND_WR_ENABLE = 3'd0,
    KIND_WR_MEMBER = 3'd1,
    KIND_WR_WAKE   = 3'd2,
    KIND_WR_POL    = 3'd3,
    KIND_SAMPLE    = 3'd4,
    KIND_READ      = 3'd5
  } kind_t;

  // Highest set bit of a word by halving; zero maps to bit 0.
  function automatic logic [4:0] top_bit(input logic [LINE_BITS-1:0] v);
    logic [LINE_BITS-1:0] x;
    logic [4:0]           b;
    x = v;
    b = '0;
    if (x[31:16] != '0) begin
      b[4] = 1'b1;
      x    = x >> 16;
    end
    if (x[15:8] != '0) begin
      b[3] = 1'b1;
      x    = x >> 8;
    end
    if (x[7:4] != '0) begin
      b[2] = 1'b1;
      x    = x >> 4;
    end
    if (x[3:2] != '0) begin
      b[1] = 1'b1;
      x    = x >> 2;
    end
    if (x[1]) begin
      b[0] = 1'b1;
    end
    return b;
  endfunction

endpackage

/* hw/rtl/gpic_member_ram.sv */
// ----------------------------------------------------------------------------
// gpic_member_ram
// Group membership words, one per (group, word) pair, with per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module gpic_member_ram #(
  parameter int DEPTH = gpic_pkg::NUM_WORDS_DEF * gpic_pkg::NUM_GROUPS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [gpic_pkg::LINE_BITS-1:0] wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [gpic_pkg::LINE_BITS-1:0] rdata
);

  logic [gpic_pkg::LINE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]               vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Registered read; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    rdata <= vld[raddr] ? mem[raddr] : '0;
  end

endmodule

/* hw/rtl/grouped_priority_interrupt_controller_top.sv */
// ----------------------------------------------------------------------------
// grouped_priority_interrupt_controller_top
// Interrupt controller for NUM_WORDS x 32 level lines sorted into NUM_GROUPS
// priority groups, with a sequential scan over the membership store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one item per bus access. s_tuser carries the kind
//   (write enable, write membership, write wake, write polarity, sample
//   lines, read cause); s_tdata carries word index, group index and data.
//   Output channel (m_*): exactly one result item per input item, in order.
//   Every item, read or not, reports irq_pending and wake_request as they
//   stand after the item's update; only a cause read fills irq_found,
//   irq_number and cause_group (zero otherwise).
// Timing:
//   After an item is accepted, the block walks the membership store one
//   entry a cycle, lowest group first and highest word first in a group,
//   through one compare unit fed by a single registered RAM read port.
//   When the scan ends, the result is loaded into the output register in
//   FINISH and the block returns to IDLE; the next item is taken only
//   then. s_tready is low meanwhile.
// Reset (rst, synchronous): clears every enable, wake, polarity and level
//   word, marks all membership entries as zero and drops m_tvalid.
// Stall: a result waits in the output register until m_tready; the block
//   still takes the next item, but holds its own result until the
//   register is free.
// ----------------------------------------------------------------------------
module grouped_priority_interrupt_controller_top #(
  parameter int NUM_WORDS  = gpic_pkg::NUM_WORDS_DEF,
  parameter int NUM_GROUPS = gpic_pkg::NUM_GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // word_index[1:0], group_index[5:2], data[37:6], zero pad
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // irq_found[0], irq_number[7:1], cause_group[11:8],
                                 // irq_pending[12], wake_request[13], zero pad
);

  localparam int LB    = gpic_pkg::LINE_BITS;
  localparam int DEPTH = NUM_WORDS * NUM_GROUPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int NB    = gpic_pkg::NUM_BITS;

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    SCAN   = 3'b010,
    FINISH = 3'b100
  } state_t;

  state_t state;

  // Input field unpack
  logic [1:0]            in_word;
  logic [3:0]            in_group;
  logic [LB-1:0]         in_data;
  gpic_pkg::kind_t       in_kind;
  logic                  acc;
  logic                  word_ok;
  logic                  group_ok;
  logic [WW-1:0]         wsel;
  logic [GW-1:0]         gsel;

  assign in_word  = s_tdata[1:0];
  assign in_group = s_tdata[5:2];
  assign in_data  = s_tdata[37:6];
  assign in_kind  = gpic_pkg::kind_t'(s_tuser);
  assign s_tready = (state == IDLE);
  assign acc      = s_tvalid && s_tready;
  assign word_ok  = (32'(in_word) < NUM_WORDS);
  assign group_ok = (32'(in_group) < NUM_GROUPS);
  assign wsel     = WW'(in_word);
  assign gsel     = GW'(in_group);

  // Per-word register files
  logic [LB-1:0] enable_w [NUM_WORDS];
  logic [LB-1:0] wake_w   [NUM_WORDS];
  logic [LB-1:0] pol_w    [NUM_WORDS];
  logic [LB-1:0] level_w  [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        enable_w[i] <= '0;
        wake_w[i]   <= '0;
        pol_w[i]    <= '0;
        level_w[i]  <= '0;
      end
    end else if (acc && word_ok) begin
      case (in_kind)
        gpic_pkg::KIND_WR_ENABLE: enable_w[wsel] <= in_data;
        gpic_pkg::KIND_WR_WAKE:   wake_w[wsel]   <= in_data;
        gpic_pkg::KIND_WR_POL:    pol_w[wsel]    <= in_data;
        gpic_pkg::KIND_SAMPLE:    level_w[wsel]  <= in_data;
        default: ;
      endcase
    end
  end

  // Membership store
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [LB-1:0] mem_rdata;

  assign mem_we    = acc && word_ok && group_ok && (in_kind == gpic_pkg::KIND_WR_MEMBER);
  assign mem_waddr = AW'(AW'(gsel) * AW'(NUM_WORDS)) + AW'(wsel);

  gpic_member_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_member (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Scan sequencer: issue side
  logic [GW-1:0] g_cnt;
  logic [WW-1:0] w_cnt;
  logic [AW-1:0] g_base;
  logic          issue_on;
  logic          issue_last;

  assign mem_raddr  = g_base + AW'(w_cnt);
  assign issue_last = (g_cnt == GW'(NUM_GROUPS - 1)) && (w_cnt == '0);

  // Scan sequencer: evaluate side (lags the issue side by the registered RAM read)
  logic          eval_en;
  logic          eval_last;
  logic [GW-1:0] g_q;
  logic [WW-1:0] w_q;
  logic [LB-1:0] sta;

  assign sta = ((level_w[w_q] ^ pol_w[w_q]) & enable_w[w_q]) & mem_rdata;

  // Accumulated scan results
  logic          is_read;
  logic          found_r;
  logic          pend_r;
  logic          wake_r;
  logic [GW-1:0] grp_r;
  logic [WW-1:0] wrd_r;
  logic [LB-1:0] sta_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      issue_on <= 1'b0;
      eval_en  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          eval_en <= 1'b0;
          if (acc) begin
            state    <= SCAN;
            issue_on <= 1'b1;
          end
        end
        SCAN: begin
          eval_en <= issue_on;
          if (issue_on && issue_last) begin
            issue_on <= 1'b0;
          end
          if (eval_en && eval_last) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          eval_en <= 1'b0;
          if (!m_tvalid || m_tready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Counters, tags and accumulators (payload, no reset needed)
  always_ff @(posedge clk) begin
    if (acc) begin
      g_cnt   <= '0;
      w_cnt   <= WW'(NUM_WORDS - 1);
      g_base  <= '0;
      is_read <= (in_kind == gpic_pkg::KIND_READ);
      found_r <= 1'b0;
      pend_r  <= 1'b0;
      wake_r  <= 1'b0;
      grp_r   <= '0;
      wrd_r   <= '0;
      sta_r   <= '0;
    end else if (state == SCAN) begin
      // Advance the issue position: highest word first, then next group
      if (issue_on && !issue_last) begin
        if (w_cnt == '0) begin
          w_cnt  <= WW'(NUM_WORDS - 1);
          g_cnt  <= g_cnt + 1'b1;
          g_base <= g_base + AW'(NUM_WORDS);
        end else begin
          w_cnt <= w_cnt - 1'b1;
        end
      end
      g_q       <= g_cnt;
      w_q       <= w_cnt;
      eval_last <= issue_on && issue_last;
      // Fold in the entry read last cycle; keep the first hit as the cause
      if (eval_en && (sta != '0)) begin
        pend_r <= 1'b1;
        if ((sta & wake_w[w_q]) != '0) begin
          wake_r <= 1'b1;
        end
        if (!found_r) begin
          found_r <= 1'b1;
          grp_r   <= g_q;
          wrd_r   <= w_q;
          sta_r   <= sta;
        end
      end
    end
  end

  // Output register
  logic          irq_found;
  logic [NB-1:0] irq_number;
  logic [3:0]    cause_group;
  logic          irq_pending;
  logic          wake_request;
  logic          hit;

  assign hit = is_read && found_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == FINISH) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == FINISH) && (!m_tvalid || m_tready)) begin
      irq_found    <= hit;
      irq_number   <= hit ? NB'((NB'(wrd_r) << 5) | NB'(gpic_pkg::top_bit(sta_r))) : '0;
      cause_group  <= hit ? 4'(grp_r) : '0;
      irq_pending  <= pend_r;
      wake_request <= wake_r;
    end
  end

  assign m_tdata = {2'b00, wake_request, irq_pending, cause_group, irq_number, irq_found};

`ifndef SYNTHESIS
  a_found_pending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && irq_found |-> irq_pending)
    else $error("cause found without pending line");

  a_number_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && irq_found |-> (NUM_WORDS > 4) || (32'(irq_number) < NUM_WORDS * LB))
    else $error("line number beyond configured lines");

  a_group_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && irq_found |-> (32'(cause_group) < NUM_GROUPS))
    else $error("cause group out of range");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> (state == SCAN) && issue_on)
    else $error("accepted item did not start a scan");
`endif

endmodule
